### rtl/bounded_array_list_engine_top_macros.svh
// Assertion macros for the bounded array list engine.
// Included by the RTL files that carry concurrent checks; expects a clk and rst in scope.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BALE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle forces another condition in the next.
`define BALE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// No dependencies; used by the interfaces, the slot cell and the top level.
`default_nettype none

package bale_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W     = 4;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 4'd0,
    OP_PUSH_HEAD = 4'd1,
    OP_INSERT    = 4'd2,
    OP_DELETE    = 4'd3,
    OP_POP_TAIL  = 4'd4,
    OP_POP_HEAD  = 4'd5,
    OP_CLEAR     = 4'd6,
    OP_FIND      = 4'd7,
    OP_READ      = 4'd8
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Per-cycle update applied by every slot cell.
  typedef enum logic [1:0] {
    MUT_NONE  = 2'd0,
    MUT_LOAD  = 2'd1,
    MUT_OPEN  = 2'd2,
    MUT_CLOSE = 2'd3
  } mut_mode_t;

  // Control bits of the query token walking down the cell chain.
  typedef struct packed {
    logic valid;
    logic find;
    logic read;
    logic hit;
  } tok_flags_t;

endpackage

`default_nettype wire

### rtl/bale_in_if.sv
// Request channel of the bounded array list engine: valid/ready plus one operation.
// Depends on bale_pkg for field widths.
`default_nettype none

interface bale_in_if;
  logic                               valid;
  logic                               ready;
  logic        [bale_pkg::OP_W-1:0]   opcode;
  logic signed [bale_pkg::VAL_W-1:0]  item_value;
  logic        [bale_pkg::POS_W-1:0]  position;

  modport source (output valid, opcode, item_value, position, input ready);
  modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

`default_nettype wire

### rtl/bale_out_if.sv
// Response channel of the bounded array list engine: valid/ready plus one result.
// Depends on bale_pkg for field widths.
`default_nettype none

interface bale_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bale_pkg::STATUS_W-1:0] status;
  logic        [bale_pkg::COUNT_W-1:0]  entry_count;
  logic        [bale_pkg::POS_W-1:0]    found_position;
  logic signed [bale_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, status, entry_count, found_position, read_value,
                  input ready);
  modport sink   (input valid, status, entry_count, found_position, read_value,
                  output ready);
endinterface

`default_nettype wire

### rtl/bale_cfg_if.sv
// Configuration write channel of the bounded array list engine (capacity register).
// Depends on bale_pkg for the register width.
`default_nettype none

interface bale_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bale_pkg::CAP_W-1:0]   capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

`default_nettype wire

### rtl/bale_slot_cell.sv
// One slot of the list: holds a word, shifts with its neighbors, and serves the
// query token as it passes. Depends on bale_pkg.
`default_nettype none

module bale_slot_cell #(
  parameter int INDEX     = 0,
  parameter int DEPTH     = bale_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bale_pkg::WORD_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  bale_pkg::mut_mode_t                mut_mode,
  input  wire  [$clog2(DEPTH)-1:0]           mut_at,
  input  wire  [WORD_BITS-1:0]               mut_word,
  input  wire  [WORD_BITS-1:0]               prev_word,
  input  wire  [WORD_BITS-1:0]               next_word,
  output logic [WORD_BITS-1:0]               word,
  input  bale_pkg::tok_flags_t               tok_in,
  input  bale_pkg::status_t                  status_in,
  input  wire  [$clog2(DEPTH+1)-1:0]         count_in,
  input  wire  [((bale_pkg::POS_W > $clog2(DEPTH+1)) ?
                 bale_pkg::POS_W : $clog2(DEPTH+1))-1:0] pos_in,
  input  wire  [WORD_BITS-1:0]               val_in,
  input  wire  [$clog2(DEPTH)-1:0]           idx_in,
  input  wire  [WORD_BITS-1:0]               data_in,
  output bale_pkg::tok_flags_t               tok_out,
  output bale_pkg::status_t                  status_out,
  output logic [$clog2(DEPTH+1)-1:0]         count_out,
  output logic [((bale_pkg::POS_W > $clog2(DEPTH+1)) ?
                 bale_pkg::POS_W : $clog2(DEPTH+1))-1:0] pos_out,
  output logic [WORD_BITS-1:0]               val_out,
  output logic [$clog2(DEPTH)-1:0]           idx_out,
  output logic [WORD_BITS-1:0]               data_out
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (bale_pkg::POS_W > CW) ? bale_pkg::POS_W : CW;

  localparam logic [IW-1:0] ME_IW = IW'(INDEX);
  localparam logic [CW-1:0] ME_CW = CW'(INDEX);
  localparam logic [PW-1:0] ME_PW = PW'(INDEX);

  logic [WORD_BITS-1:0]  word_next;
  bale_pkg::tok_flags_t  tok_next;
  bale_pkg::status_t     status_next;
  logic [IW-1:0]         idx_next;
  logic [WORD_BITS-1:0]  data_next;
  logic                  in_list;

  always_comb begin
    word_next = word;
    case (mut_mode)
      bale_pkg::MUT_LOAD: begin
        if (ME_IW == mut_at) word_next = mut_word;
      end
      bale_pkg::MUT_OPEN: begin
        if (ME_IW > mut_at) word_next = prev_word;
        else if (ME_IW == mut_at) word_next = mut_word;
      end
      bale_pkg::MUT_CLOSE: begin
        if (ME_IW >= mut_at) word_next = next_word;
      end
      default: word_next = word;
    endcase
  end

  assign in_list = (ME_CW < count_in);

  always_comb begin
    tok_next    = tok_in;
    status_next = status_in;
    idx_next    = idx_in;
    data_next   = data_in;
    // first match wins: later cells see hit already set
    if (tok_in.find && !tok_in.hit && in_list && (word == val_in)) begin
      tok_next.hit = 1'b1;
      status_next  = bale_pkg::ST_OK;
      idx_next     = ME_IW;
    end
    if (tok_in.read && in_list && (pos_in == ME_PW)) begin
      data_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    status_out <= status_next;
    count_out  <= count_in;
    pos_out    <= pos_in;
    val_out    <= val_in;
    idx_out    <= idx_next;
    data_out   <= data_next;
  end

endmodule

`default_nettype wire

### rtl/bounded_array_list_engine_top.sv
// Top level of the bounded array list engine: control, capacity register, result
// buffering and the chain of slot cells. Depends on bale_pkg, the channel
// interfaces, bale_slot_cell and bounded_array_list_engine_top_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req.valid/ready    | opcode, item_value, position
//   rsp     | out       | rsp.valid/ready    | status, entry_count, found_position, read_value
//   cfg     | in        | cfg.valid/ready    | capacity_limit (always ready)
//
// Pushes, pops, inserts, deletes and clear update the entry count and any loaded or shifted
// slots in the accept cycle; rsp gets the result through the holding stage and the output
// register. Find and read send a token down the cell chain, one cell per cycle, before the
// result enters the holding stage. req stays low while a token walks or a result waits in
// the holding stage; a stalled rsp holds one result in the output register and one behind it.
// Synchronous reset empties the list and sets the capacity to 16; slots are not cleared.
`default_nettype none

`include "bounded_array_list_engine_top_macros.svh"

module bounded_array_list_engine_top #(
  parameter int DEPTH     = bale_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bale_pkg::WORD_BITS_DEF
) (
  input wire         clk,
  input wire         rst,
  bale_in_if.sink    req,
  bale_out_if.source rsp,
  bale_cfg_if.sink   cfg
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = (bale_pkg::POS_W > CW) ? bale_pkg::POS_W : CW;
  localparam int CMPW = (bale_pkg::CAP_W > CW) ? bale_pkg::CAP_W : CW;
  localparam int XW   = (WORD_BITS > bale_pkg::VAL_W) ? WORD_BITS : bale_pkg::VAL_W;

  // list state
  logic [CW-1:0]                 count;
  logic [bale_pkg::CAP_W-1:0]    cap;
  logic                          busy;

  // decode
  logic                          acc;
  logic                          is_query;
  bale_pkg::mut_mode_t           mode;
  bale_pkg::mut_mode_t           cell_mode;
  logic [IW-1:0]                 at;
  bale_pkg::status_t             st;
  logic [CW-1:0]                 count_next;
  logic [CMPW-1:0]               cap_ext;
  logic [CW-1:0]                 eff_cap;
  logic                          full;
  logic [PW-1:0]                 pos_ext;
  logic [PW-1:0]                 count_pw;
  logic [XW-1:0]                 val_x;
  logic [WORD_BITS-1:0]          val_word;

  // cell chain
  logic [WORD_BITS-1:0]          sw [DEPTH];
  bale_pkg::tok_flags_t          tf [DEPTH+1];
  bale_pkg::status_t             ts [DEPTH+1];
  logic [CW-1:0]                 tc [DEPTH+1];
  logic [PW-1:0]                 tp [DEPTH+1];
  logic [WORD_BITS-1:0]          tv [DEPTH+1];
  logic [IW-1:0]                 ti [DEPTH+1];
  logic [WORD_BITS-1:0]          td [DEPTH+1];

  // result holding stage and output register
  logic                          pend_valid;
  bale_pkg::status_t             pend_status;
  logic [CW-1:0]                 pend_count;
  logic [IW-1:0]                 pend_idx;
  logic [WORD_BITS-1:0]          pend_data;
  logic                          move;
  logic [XW-1:0]                 rd_x;

  logic                          out_valid;
  logic [bale_pkg::STATUS_W-1:0] out_status;
  logic [bale_pkg::COUNT_W-1:0]  out_count;
  logic [bale_pkg::POS_W-1:0]    out_found;
  logic [bale_pkg::VAL_W-1:0]    out_read;

  assign req.ready = !busy && !pend_valid;
  assign cfg.ready = 1'b1;
  assign acc       = req.valid && req.ready;

  assign cap_ext  = CMPW'(cap);
  always_comb begin
    if (cap_ext == '0) eff_cap = CW'(1);
    else if (cap_ext > CMPW'(DEPTH)) eff_cap = CW'(DEPTH);
    else eff_cap = CW'(cap_ext);
  end
  assign full = (count >= eff_cap);

  assign pos_ext  = PW'(req.position);
  assign count_pw = PW'(count);
  assign val_x    = XW'(req.item_value);
  assign val_word = val_x[WORD_BITS-1:0];

  always_comb begin
    mode       = bale_pkg::MUT_NONE;
    at         = '0;
    st         = bale_pkg::ST_OK;
    count_next = count;
    is_query   = 1'b0;
    case (bale_pkg::opcode_t'(req.opcode))
      bale_pkg::OP_PUSH_TAIL: begin
        if (full) st = bale_pkg::ST_FULL;
        else begin
          mode       = bale_pkg::MUT_LOAD;
          at         = IW'(count);
          count_next = count + CW'(1);
        end
      end
      bale_pkg::OP_PUSH_HEAD: begin
        if (full) st = bale_pkg::ST_FULL;
        else begin
          mode       = bale_pkg::MUT_OPEN;
          count_next = count + CW'(1);
        end
      end
      bale_pkg::OP_INSERT: begin
        // index test comes before the full test
        if (pos_ext > count_pw) st = bale_pkg::ST_BADIDX;
        else if (full) st = bale_pkg::ST_FULL;
        else begin
          mode       = bale_pkg::MUT_OPEN;
          at         = IW'(pos_ext);
          count_next = count + CW'(1);
        end
      end
      bale_pkg::OP_DELETE: begin
        if (count == '0) st = bale_pkg::ST_EMPTY;
        else if (pos_ext >= count_pw) st = bale_pkg::ST_BADIDX;
        else begin
          mode       = bale_pkg::MUT_CLOSE;
          at         = IW'(pos_ext);
          count_next = count - CW'(1);
        end
      end
      bale_pkg::OP_POP_TAIL: begin
        if (count == '0) st = bale_pkg::ST_EMPTY;
        else count_next = count - CW'(1);
      end
      bale_pkg::OP_POP_HEAD: begin
        if (count == '0) st = bale_pkg::ST_EMPTY;
        else begin
          mode       = bale_pkg::MUT_CLOSE;
          count_next = count - CW'(1);
        end
      end
      bale_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      bale_pkg::OP_FIND: begin
        is_query = 1'b1;
        st       = bale_pkg::ST_NOTFOUND;
      end
      bale_pkg::OP_READ: begin
        is_query = 1'b1;
        if (pos_ext >= count_pw) st = bale_pkg::ST_BADIDX;
      end
      default: st = bale_pkg::ST_OK;
    endcase
  end

  assign cell_mode = acc ? mode : bale_pkg::MUT_NONE;

  // launch the query token into the head of the chain: valid, find, read, hit
  assign tf[0] = {acc && is_query,
                  bale_pkg::opcode_t'(req.opcode) == bale_pkg::OP_FIND,
                  bale_pkg::opcode_t'(req.opcode) == bale_pkg::OP_READ,
                  1'b0};
  assign ts[0] = st;
  assign tc[0] = count;
  assign tp[0] = pos_ext;
  assign tv[0] = val_word;
  assign ti[0] = '0;
  assign td[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w;
    logic [WORD_BITS-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = sw[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = sw[i];
    end else begin : g_inner
      assign next_w = sw[i+1];
    end

    bale_slot_cell #(
      .INDEX     (i),
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .mut_mode   (cell_mode),
      .mut_at     (at),
      .mut_word   (val_word),
      .prev_word  (prev_w),
      .next_word  (next_w),
      .word       (sw[i]),
      .tok_in     (tf[i]),
      .status_in  (ts[i]),
      .count_in   (tc[i]),
      .pos_in     (tp[i]),
      .val_in     (tv[i]),
      .idx_in     (ti[i]),
      .data_in    (td[i]),
      .tok_out    (tf[i+1]),
      .status_out (ts[i+1]),
      .count_out  (tc[i+1]),
      .pos_out    (tp[i+1]),
      .val_out    (tv[i+1]),
      .idx_out    (ti[i+1]),
      .data_out   (td[i+1])
    );
  end

  assign move = pend_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cap        <= bale_pkg::CAP_RESET;
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) cap <= cfg.capacity_limit;
      if (acc) count <= count_next;

      if (acc && is_query) busy <= 1'b1;
      else if (tf[DEPTH].valid) busy <= 1'b0;

      if ((acc && !is_query) || tf[DEPTH].valid) pend_valid <= 1'b1;
      else if (move) pend_valid <= 1'b0;

      if (move) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !is_query) begin
      pend_status <= st;
      pend_count  <= count_next;
      pend_idx    <= '0;
      pend_data   <= '0;
    end else if (tf[DEPTH].valid) begin
      pend_status <= ts[DEPTH];
      pend_count  <= tc[DEPTH];
      pend_idx    <= ti[DEPTH];
      pend_data   <= td[DEPTH];
    end
  end

  // read data comes back sign-extended from the slot width
  assign rd_x = XW'(signed'(pend_data));

  always_ff @(posedge clk) begin
    if (move) begin
      out_status <= pend_status;
      out_count  <= bale_pkg::COUNT_W'(pend_count);
      out_found  <= bale_pkg::POS_W'(pend_idx);
      out_read   <= rd_x[bale_pkg::VAL_W-1:0];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.entry_count    = out_count;
  assign rsp.found_position = out_found;
  assign rsp.read_value     = out_read;

  `BALE_CHECK(a_walk_blocks_req, tf[DEPTH].valid |-> !(req.valid && req.ready),
    "request transfer while a query token is still in the chain")
  `BALE_CHECK(a_hold_free_on_walk, (busy || tf[DEPTH].valid) |-> !pend_valid,
    "holding stage occupied while a query is in flight")
  `BALE_CHECK_NEXT(a_count_hold, !(req.valid && req.ready), count == $past(count),
    "entry count changed without a request transfer")

endmodule

`default_nettype wire
